// ===== rtl/core/chol_pkg.sv =====
// package for the cholesky factorization block
// holds widths, store geometry and the triangle index helper; no dependencies
`default_nettype none
package chol_pkg;
    localparam int MaxDim     = 8;
    localparam int ValBits    = 32;
    localparam int FracBits   = 16;
    localparam int StoreDepth = MaxDim * (MaxDim + 1) / 2;
    localparam int AddrBits   = $clog2(StoreDepth);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_NPD = 1'b1;

    // row-major lower triangle position
    function automatic logic [AddrBits-1:0] tri_pos(input logic [2:0] r, input logic [2:0] c);
        logic [7:0] t;
        begin
            t = ({5'd0, r} * ({5'd0, r} + 8'd1)) >> 1;
            tri_pos = AddrBits'(t + {5'd0, c});
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/cholesky_factorization.sv =====
// cholesky factorization top level: load, gaxpy factorization and emit sequencer
// depends on chol_pkg
`default_nettype none
// Usage
//  s_axis carries one lower-triangle entry per word; tdata = {entry_value,
//  col_index, row_index}, MSB first (zero filled to 40 bits), tlast marks
//  the final entry and starts the run. Entries above the diagonal are dropped.
//  i_cfg_valid/o_cfg_ready write matrix_size (n, clamped to 1..8) while idle.
//  Loading takes one word per cycle. After the last word the block runs the
//  factorization on one shared datapath: one multiply-accumulate per pass
//  through S_RD_A, S_RD_B and S_MAC on the store read port, a 32-step two-bit
//  square root per column after the pivot read, with a final rounding step,
//  and a 49-step restoring divide per column entry. It then emits L row-major
//  on m_axis, reading each word from the store once the output register is free
//  (tdata = {factor_value, out_col, out_row}, tuser = status, tlast on the
//  final word). A failing pivot yields a single word with status 1. The block
//  takes no input while it works or emits; a stalled receiver simply holds
//  the output register. Reset returns to loading and sets n to 8; the store
//  itself is not cleared.
module cholesky_factorization (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [3:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // row_index[2:0], col_index[5:3], entry_value[37:6]
    input  wire         s_axis_tlast,   // last_entry
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], factor_value[37:6]
    output logic        m_axis_tuser,   // status
    output logic        m_axis_tlast    // last_result
);
    import chol_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_COL, S_ACC_INIT, S_RD_A, S_RD_B, S_MAC, S_UPD_WR,
        S_PIV, S_SQRT, S_DIV_RD, S_DIV, S_DIV_WR, S_EMIT_RD, S_EMIT, S_FAIL
    } t_state;

    t_state r_state;
    logic [3:0]  r_n;
    logic [2:0]  r_i, r_j, r_k;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_a;
    logic signed [31:0] r_rd;
    logic [63:0] r_sq_rem, r_sq_x;
    logic [47:0] r_root;
    logic [5:0]  r_cnt;
    logic [48:0] r_num;
    logic [49:0] r_rem;
    logic        r_neg;
    logic [39:0] r_odata;
    logic        r_ovalid, r_ouser, r_olast;

    logic signed [31:0] mem [StoreDepth];

    logic [AddrBits-1:0] rd_addr;
    logic                wr_en;
    logic [AddrBits-1:0] wr_addr;
    logic signed [31:0]  wr_data;

    logic [2:0]  in_row, in_col;
    logic signed [31:0] in_val;
    assign in_row = s_axis_tdata[2:0];
    assign in_col = s_axis_tdata[5:3];
    assign in_val = s_axis_tdata[37:6];

    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = (r_state == S_LOAD) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    logic [2:0] n_m1;
    assign n_m1 = 3'(r_n - 4'd1);

    // shared multiplier
    logic signed [63:0] prod;
    assign prod = 64'(r_a * r_rd);

    // saturating subtract of the product
    logic signed [64:0] diff;
    logic signed [63:0] acc_sub;
    assign diff = {r_acc[63], r_acc} - {prod[63], prod};
    always_comb begin
        if (diff[64] != diff[63]) acc_sub = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else acc_sub = diff[63:0];
    end

    // Q32.32 to Q16.16 round half up, saturate
    logic signed [48:0] rnd;
    logic signed [31:0] rnd_sat;
    assign rnd = 49'(r_acc >>> FracBits) + 49'(r_acc[15]);
    always_comb begin
        if (rnd > 49'sh7FFFFFFF) rnd_sat = 32'sh7FFFFFFF;
        else if (rnd < -49'sh80000000) rnd_sat = -32'sh80000000;
        else rnd_sat = rnd[31:0];
    end

    // square root step (two bits per step)
    logic [63:0] sq_trial;
    assign sq_trial = {16'd0, r_root} + r_sq_x;

    // restoring divide step
    logic [49:0] rem_sh, rem_try;
    assign rem_sh  = {r_rem[48:0], r_num[48]};
    assign rem_try = rem_sh - {2'd0, r_root};

    // division rounding and saturation
    logic [49:0] q_rnd;
    logic signed [31:0] q_sat;
    always_comb begin
        q_rnd = {1'b0, r_num} + (({r_rem[48:0], 1'b0} >= {2'd0, r_root}) ? 50'd1 : 50'd0);
        if (!r_neg) q_sat = (q_rnd > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q_rnd);
        else q_sat = (q_rnd > 50'h80000000) ? -32'sh80000000 : 32'(-q_rnd);
    end

    logic [31:0] a_mag;
    assign a_mag = r_rd[31] ? 32'(-r_rd) : 32'(r_rd);

    // read address and write port selection
    always_comb begin
        rd_addr = tri_pos(r_j, r_i);
        wr_en = 1'b0;
        wr_addr = tri_pos(r_j, r_i);
        wr_data = rnd_sat;
        case (r_state)
            S_LOAD: begin
                wr_en   = s_axis_tvalid && (in_col <= in_row);
                wr_addr = tri_pos(in_row, in_col);
                wr_data = in_val;
            end
            S_RD_A:    rd_addr = tri_pos(r_j, r_k);
            S_RD_B:    rd_addr = tri_pos(r_i, r_k);
            S_UPD_WR:  wr_en = 1'b1;
            S_DIV_WR: begin
                wr_en = 1'b1;
                wr_data = q_sat;
            end
            default: ;
        endcase
    end

    // store
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= 4'd8;
            r_ovalid <= 1'b0;
            r_cnt    <= 6'd0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_data == 4'd0) r_n <= 4'd1;
                        else if (i_cfg_data > 4'd8) r_n <= 4'd8;
                        else r_n <= i_cfg_data;
                    end
                    if (s_axis_tvalid && s_axis_tlast) begin
                        r_i <= 3'd0;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    r_j <= r_i;
                    r_state <= (r_i == 3'd0) ? S_PIV : S_ACC_INIT;
                end
                S_ACC_INIT: begin
                    r_k <= 3'd0;
                    r_state <= S_RD_A;
                end
                S_RD_A: begin
                    // first word is A(j,i) when k hasn't started
                    if (r_k == 3'd0) r_acc <= {{16{r_rd[31]}}, r_rd, 16'd0};
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_a <= r_rd;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_acc <= acc_sub;
                    if (r_k == 3'(r_i - 3'd1)) r_state <= S_UPD_WR;
                    else begin
                        r_k <= r_k + 3'd1;
                        r_state <= S_RD_A;
                    end
                end
                S_UPD_WR: begin
                    if (r_j == n_m1) begin
                        r_j <= r_i;
                        r_state <= S_PIV;
                    end else begin
                        r_j <= r_j + 3'd1;
                        r_state <= S_ACC_INIT;
                    end
                end
                S_PIV: r_state <= S_SQRT;  // read of pivot in flight
                S_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        if (r_rd <= 0) begin
                            r_state <= S_FAIL;
                        end else begin
                            r_sq_rem <= {16'd0, r_rd, 16'd0};
                            r_sq_x   <= 64'h4000_0000_0000_0000;
                            r_root   <= 48'd0;
                            r_cnt    <= 6'd1;
                        end
                    end else if (r_sq_x != 64'd0) begin
                        if (r_sq_rem >= sq_trial) begin
                            r_sq_rem <= r_sq_rem - sq_trial;
                            r_root   <= 48'(({16'd0, r_root} >> 1) + r_sq_x);
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_sq_x <= r_sq_x >> 2;
                    end else begin
                        if (r_sq_rem > {16'd0, r_root}) r_root <= r_root + 48'd1;
                        r_cnt <= 6'd0;
                        r_state <= S_DIV_RD;
                    end
                end
                S_DIV_RD: begin
                    r_cnt <= 6'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_neg <= r_rd[31];
                        r_num <= {1'b0, a_mag, 16'd0};
                        r_rem <= 50'd0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'd49) begin
                        if (!rem_try[49]) begin
                            r_rem <= rem_try;
                            r_num <= {r_num[47:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[47:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end else begin
                        r_state <= S_DIV_WR;
                    end
                end
                S_DIV_WR: begin
                    r_cnt <= 6'd0;
                    if (r_j == n_m1) begin
                        if (r_i == n_m1) begin
                            r_j <= 3'd0;
                            r_i <= 3'd0;
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_i <= r_i + 3'd1;
                            r_state <= S_COL;
                        end
                    end else begin
                        r_j <= r_j + 3'd1;
                        r_state <= S_DIV_RD;
                    end
                end
                // emit: r_j is row, r_i is column
                S_EMIT_RD: if (!r_ovalid || m_axis_tready) r_state <= S_EMIT;
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {2'd0, r_rd, r_i, r_j};
                    r_ouser  <= STATUS_OK;
                    r_olast  <= (r_j == n_m1) && (r_i == r_j);
                    if (r_i == r_j) begin
                        r_i <= 3'd0;
                        if (r_j == n_m1) r_state <= S_LOAD;
                        else begin
                            r_j <= r_j + 3'd1;
                            r_state <= S_EMIT_RD;
                        end
                    end else begin
                        r_i <= r_i + 3'd1;
                        r_state <= S_EMIT_RD;
                    end
                end
                // wait for an empty output register
                S_FAIL: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {34'd0, r_i, r_i};
                        r_ouser  <= STATUS_NPD;
                        r_olast  <= 1'b1;
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/chol_checker.sv =====
// port-level checker for cholesky_factorization, bound to the top level
// depends on chol_pkg for status codes
`default_nettype none
module chol_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);
    import chol_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // failure word is always final
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_NPD |-> m_axis_tlast)
        else $error("failure word not last");

    // failure word names a diagonal position
    a_fail_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_NPD |-> m_axis_tdata[2:0] == m_axis_tdata[5:3])
        else $error("failure word off diagonal");

    // every output word lies on or below the diagonal
    a_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:3] <= m_axis_tdata[2:0])
        else $error("output above diagonal");
endmodule

bind cholesky_factorization chol_checker u_chol_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// ===== tb/cholesky_factorization_tb.sv =====
// self-checking testbench for the cholesky factorization block
// depends on chol_pkg and cholesky_factorization; carries its own fixed-point factor predictor
`default_nettype none
module cholesky_factorization_tb;
    import chol_pkg::*;

    localparam int      TriDepth  = 36;
    localparam int      RandItems = 500;
    localparam int      DogLimit  = 40000;
    localparam longint  LongMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint  LongMin   = 64'sh8000_0000_0000_0000;
    localparam int      NoCfg     = -1;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        status;
        logic        last;
    } factor_word_t;

    typedef struct {
        int          cfg;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [31:0] want_value;
        logic        want_status;
    } load_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    cholesky_factorization u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // row_index, col_index, entry_value
        .s_axis_tlast  (s_axis_tlast),   // last_entry
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_row, out_col, factor_value
        .m_axis_tuser  (m_axis_tuser),   // status
        .m_axis_tlast  (m_axis_tlast)    // last_result
    );

    // predictor state
    int            l_store [TriDepth];
    bit            written [TriDepth];
    logic [3:0]    size_reg;
    factor_word_t  pending_factors[$];

    // bookkeeping
    int  n_items;
    int  n_results;
    int  n_runs;
    int  n_npd;
    int  n_errors;
    int  idle_count;
    bit  quiet;
    bit  typed_next;
    logic [31:0] typed_value;
    logic        typed_status;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int tri_index(input int r, input int c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic int eff_size(input logic [3:0] s);
        if (s < 1) return 1;
        if (s > 8) return 8;
        return int'(s);
    endfunction

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint sub_sat(input longint a, input longint b);
        if (b > 0 && a < LongMin + b) return LongMin;
        if (b < 0 && a > LongMax + b) return LongMax;
        return a - b;
    endfunction

    // q32.32 to q16.16, nearest with ties upward
    function automatic longint round_q16(input longint v);
        logic [63:0] u;
        logic [63:0] q;
        u = v ^ 64'h8000_0000_0000_0000;
        q = u >> 16;
        if (u[15:0] >= 16'h8000) q = q + 1;
        return longint'(q) - (longint'(1) << 47);
    endfunction

    function automatic logic [63:0] root_nearest(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] bt;
        rem = x;
        r   = 0;
        bt  = 64'd1 << 62;
        while (bt > rem) bt = bt >> 2;
        while (bt != 0) begin
            if (rem >= r + bt) begin
                rem = rem - (r + bt);
                r   = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        if (rem > r) r = r + 1;
        return r;
    endfunction

    // (a << 16) / root, nearest with ties away from zero
    function automatic longint scaled_div(input longint a, input logic [63:0] root);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rm;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        num = mag << 16;
        q   = num / root;
        rm  = num % root;
        if (rm >= root - rm) q = q + 1;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    // factor the held triangle in place and queue the words the block should emit
    task automatic predict_factor();
        int           n;
        longint       acc;
        logic [63:0]  root;
        factor_word_t w;
        n = eff_size(size_reg);
        n_runs++;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                for (int j = i; j < n; j++) begin
                    acc = longint'(l_store[tri_index(j, i)]) * 65536;
                    for (int k = 0; k < i; k++)
                        acc = sub_sat(acc, longint'(l_store[tri_index(j, k)]) *
                                           longint'(l_store[tri_index(i, k)]));
                    l_store[tri_index(j, i)] = clamp32(round_q16(acc));
                end
            end
            if (l_store[tri_index(i, i)] <= 0) begin
                w = '{row: 3'(i), col: 3'(i), value: 32'd0, status: STATUS_NPD, last: 1'b1};
                pending_factors.push_back(w);
                n_npd++;
                return;
            end
            root = root_nearest(64'(l_store[tri_index(i, i)]) << 16);
            for (int j = i; j < n; j++)
                l_store[tri_index(j, i)] = clamp32(scaled_div(l_store[tri_index(j, i)], root));
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) begin
                w.row    = 3'(r);
                w.col    = 3'(c);
                w.value  = l_store[tri_index(r, c)];
                w.status = STATUS_OK;
                w.last   = (r == n - 1 && c == r);
                pending_factors.push_back(w);
            end
    endtask

    // monitor: predict on accepted entries, check accepted factor words
    always @(posedge i_clk) begin
        factor_word_t got;
        factor_word_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) size_reg <= i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                n_items++;
                if (s_axis_tdata[5:3] <= s_axis_tdata[2:0])
                    l_store[tri_index(s_axis_tdata[2:0], s_axis_tdata[5:3])] =
                        s_axis_tdata[37:6];
                if (s_axis_tlast) begin
                    predict_factor();
                    // a typed row pins down the single word it causes
                    if (typed_next) begin
                        pending_factors[$].value  = typed_value;
                        pending_factors[$].status = typed_status;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got = '{row: m_axis_tdata[2:0], col: m_axis_tdata[5:3],
                        value: m_axis_tdata[37:6], status: m_axis_tuser,
                        last: m_axis_tlast};
                if (pending_factors.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected word %p", got);
                end else begin
                    want = pending_factors.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_count <= 0;
        end else if (idle_count >= DogLimit) begin
            $display("watchdog expired with %0d words pending", pending_factors.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // receiver stalls in bursts
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready = 1'b0;
            end else if ($urandom_range(4) == 0) begin
                stall = $urandom_range(0, 3);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // release the input bus, then wait for every predicted word
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_factors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] s);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = s;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one entry word, with an optional gap in front
    task automatic send_entry(input logic [2:0] r, input logic [2:0] c, input logic [31:0] v,
                              input logic last);
        if (!quiet && $urandom_range(3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, v, c, r};
        s_axis_tlast  = last;
        if (c <= r) written[tri_index(r, c)] = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random noise word: above the diagonal, or a real entry outside the active size
    task automatic send_noise(input int n);
        logic [2:0] r;
        logic [2:0] c;
        if (n < 8 && $urandom_range(1) == 0) begin
            r = 3'($urandom_range(n, 7));
            c = 3'($urandom_range(0, r));
        end else begin
            c = 3'($urandom_range(1, 7));
            r = 3'($urandom_range(0, c - 1));
        end
        send_entry(r, c, $urandom, 1'b0);
    endtask

    // one factorization run with random content
    task automatic random_run();
        int          n;
        int          kind;
        int          cells[$];
        int          tmp;
        int          pick;
        int          cnt;
        int          r;
        int          c;
        bit          ready;
        longint      b_mat [8][8];
        longint      a_val;
        logic [31:0] v;
        logic        tail_above;
        if ($urandom_range(2) == 0) begin
            case ($urandom_range(5))
                0: write_size(4'd0);
                1: write_size(4'd1);
                2: write_size(4'd8);
                3: write_size(4'd15);
                default: write_size(4'($urandom_range(0, 15)));
            endcase
        end
        wait_drained();
        n = eff_size(size_reg);
        ready = 1'b1;
        for (int k = 0; k < tri_index(n, 0); k++) if (!written[k]) ready = 1'b0;
        kind = $urandom_range(99);
        if (kind >= 85 && !ready) kind = 0;
        // well-formed symmetric positive-definite content from b * b'
        for (int i = 0; i < n; i++)
            for (int j = 0; j < 8; j++)
                b_mat[i][j] = (j <= i) ? longint'($urandom_range(0, 262144)) - 131072 : 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++) cells.push_back(tri_index(i, j));
        for (int k = cells.size() - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            tmp = cells[k];
            cells[k] = cells[pick];
            cells[pick] = tmp;
        end
        cnt = (kind >= 85) ? $urandom_range(1, cells.size()) : cells.size();
        tail_above = ($urandom_range(9) == 0);
        for (int k = 0; k < cnt; k++) begin
            r = 0;
            while (tri_index(r + 1, 0) <= cells[k]) r++;
            c = cells[k] - tri_index(r, 0);
            a_val = 0;
            for (int m = 0; m <= c; m++) a_val += (b_mat[r][m] * b_mat[c][m]) >>> 16;
            if (r == c) a_val += 65536 * $urandom_range(1, 4);
            if (kind < 60) v = 32'(a_val);
            else if (kind < 70) v = (r == c && $urandom_range(2) == 0) ? -32'(a_val) : 32'(a_val);
            else if (kind < 78) v = $urandom;
            else begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'($urandom_range(0, 3));
                    default: v = $urandom;
                endcase
            end
            if (!quiet && $urandom_range(4) == 0) send_noise(n);
            send_entry(3'(r), 3'(c), v, (k == cnt - 1) && !tail_above);
        end
        // a last mark on an ignored word still starts the run
        if (tail_above) send_entry(3'd0, 3'($urandom_range(1, 7)), $urandom, 1'b1);
    endtask

    // directed stimulus
    load_row_t load_table [] = '{
        '{1,     0, 0, 32'h0001_0000, 1, 1, 32'h0001_0000, STATUS_OK},
        '{NoCfg, 0, 0, 32'h0000_0000, 1, 1, 32'h0000_0000, STATUS_NPD},
        '{NoCfg, 0, 0, 32'h8000_0000, 1, 1, 32'h0000_0000, STATUS_NPD},
        '{NoCfg, 0, 0, 32'h7FFF_FFFF, 1, 0, 32'h0, STATUS_OK},
        '{NoCfg, 0, 0, 32'hFFFF_FFFF, 1, 1, 32'h0000_0000, STATUS_NPD},
        '{NoCfg, 0, 1, 32'h1234_5678, 1, 0, 32'h0, STATUS_OK},
        '{0,     0, 0, 32'h0004_0000, 1, 1, 32'h0002_0000, STATUS_OK},
        '{2,     0, 0, 32'h0004_0000, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 0, 32'h0002_0000, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 0, 1, 32'hFFFF_FFFF, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 7, 7, 32'hAAAA_AAAA, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 1, 32'h0005_0000, 1, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 1, 32'h0001_0000, 1, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 0, 32'h7FFF_FFFF, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 0, 0, 32'h0000_0001, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 1, 32'h8000_0000, 1, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 0, 32'h8000_0000, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h0, STATUS_OK},
        '{NoCfg, 1, 1, 32'h7FFF_FFFF, 1, 0, 32'h0, STATUS_OK}
    };

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 4'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        size_reg      = 4'd8;
        n_items = 0;  n_results = 0;  n_runs = 0;  n_npd = 0;
        n_errors = 0; idle_count = 0; quiet = 1'b0; typed_next = 1'b0;
        foreach (l_store[k]) begin
            l_store[k] = 0;
            written[k] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (load_table[k]) begin
            if (load_table[k].cfg != NoCfg) write_size(4'(load_table[k].cfg));
            wait_drained();
            typed_next   = load_table[k].typed;
            typed_value  = load_table[k].want_value;
            typed_status = load_table[k].want_status;
            send_entry(load_table[k].row, load_table[k].col, load_table[k].value,
                       load_table[k].last);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait_drained();
        typed_next = 1'b0;

        // full size before the random runs; a partial load is only chosen once every entry in use holds a written value
        write_size(4'd8);
        while (n_items < RandItems + load_table.size()) begin
            if (n_items > RandItems + load_table.size() - 60) quiet = 1'b1;
            random_run();
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("runs %0d, entries %0d, factor words %0d, rejected matrices %0d",
                 n_runs, n_items, n_results, n_npd);
        $display("sizes 0..15 written, idle and stall bursts on both sides, %0d errors",
                 n_errors);
        if (n_errors == 0 && pending_factors.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
